// ===== design/rbae_pkg.sv =====
// Shared types, widths and constants for the range breakout ATR energy block.
`timescale 1ns / 1ps
package rbae_pkg;

    localparam int PRICE_W     = 32;
    localparam int MAX_LOOK    = 256;
    localparam int LOOK_AW     = 8;     // address bits of the high/low ring
    localparam int ATR_AW      = 6;     // address bits of the true range ring
    localparam int LOOK_CW     = 9;     // bar count 1..256
    localparam int ATR_CW      = 7;     // bar count 1..64
    localparam int SUM_W       = 38;    // true range sum over up to 64 bars
    localparam int DIV_W       = 54;    // divider dividend and quotient width
    localparam int ENERGY_W    = 32;
    localparam int ATR_W       = 40;
    localparam int ENERGY_FRAC = 16;
    localparam int ATR_FRAC    = 8;
    localparam int CFG_W       = 9;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_LOOKBACK = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATR_SPAN = 1'b1;

    localparam logic [8:0] LOOKBACK_RESET = 9'd50;
    localparam logic [5:0] ATR_SPAN_RESET = 6'd14;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_MUL,
        ST_LAUNCH,
        ST_DIV_E,
        ST_DIV_A,
        ST_DONE
    } rbae_state_t;

    typedef struct packed {
        logic               start;
        logic [LOOK_CW-1:0] look_cnt;   // prior bars in the channel
        logic [ATR_CW-1:0]  atr_prior;  // prior true ranges in the sum
        logic               wr_en;      // store high/low, advance pointer
        logic               wr_tr;      // also store the true range
        logic [PRICE_W-1:0] bar_high;
        logic [PRICE_W-1:0] bar_low;
        logic [PRICE_W-1:0] true_range;
    } win_cmd_t;

    typedef struct packed {
        logic               done;
        logic [PRICE_W-1:0] chan_high;
        logic [PRICE_W-1:0] chan_low;
        logic [SUM_W-1:0]   tr_sum;
    } win_stat_t;

endpackage

// ===== design/range_breakout_atr_energy_top.sv =====
// Top level of the range breakout ATR energy block.
`timescale 1ns / 1ps
// Usage:
//   One price bar (high, low, close) enters per transfer on the s_ channel.
//   The first bar after reset is only stored and gives no result; every later
//   bar gives one result on the m_ channel: breakout energy (Q16.16), channel
//   high and low over the prior window, ATR (8 fraction bits), and a zero-ATR
//   flag on m_tuser.
//   Per bar, both ring walks run in parallel, one entry per cycle from a
//   synchronous memory: min(lookback_bars, bars seen) highs and lows, and one
//   less than min(atr_span + 1, bars seen) true ranges. When the ATR is not
//   zero, two passes of the shared bit-serial divider follow; a zero ATR
//   skips them. One bar is in work at a time.
//   s_tready is high while no bar is in work; a finished result waits in the
//   output register, so the next bar may be accepted while the receiver
//   stalls. Only the write-back of a finished bar waits for a free output register.
//   Reset (aresetn low, synchronous) clears pointers, counts, previous close
//   and handshakes and reloads the registers to lookback 50 and span 14;
//   ring contents need no clearing, only written entries are ever read.
//   Configure through cfg_we/cfg_addr/cfg_wdata only while idle.
module range_breakout_atr_energy_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // bar_high[31:0], bar_low[63:32], bar_close[95:64]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // breakout_energy[31:0], channel_high[63:32],
                                    // channel_low[95:64], atr_value[135:96]
    output logic         m_tuser,   // zero_atr
    input  logic         cfg_we,
    input  logic [rbae_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [rbae_pkg::CFG_W-1:0]     cfg_wdata
);
    localparam int PW = rbae_pkg::PRICE_W;

    rbae_pkg::rbae_state_t state_reg, state_next;

    logic [8:0]  lookback_reg;
    logic [5:0]  atr_span_reg;
    logic [PW-1:0] prev_close_reg;
    logic [15:0] bars_seen_reg;

    logic [PW-1:0] h_reg, l_reg, c_reg, tr_reg, hi_reg, lo_reg, dist_reg;
    logic [rbae_pkg::ATR_CW-1:0] cnt2_reg;
    logic [rbae_pkg::SUM_W-1:0]  sum_reg, prod_reg;
    logic                        zero_reg;
    logic [rbae_pkg::ENERGY_W-1:0] energy_reg;
    logic [rbae_pkg::ATR_W-1:0]    atr_reg;

    logic         m_valid_reg;
    logic [135:0] m_data_reg;
    logic         m_user_reg;

    logic [PW-1:0] in_high, in_low, in_close;
    logic          accept, first_bar, out_free;
    logic [PW-1:0] tr_hl, tr_h, tr_l, tr_cur;
    logic [rbae_pkg::LOOK_CW-1:0] look_eff, look_cnt;
    logic [rbae_pkg::ATR_CW-1:0]  span, cnt2;
    logic [rbae_pkg::SUM_W-1:0]   sum_full;

    rbae_pkg::win_cmd_t  win_cmd;
    rbae_pkg::win_stat_t win_stat;

    logic                       div_start, div_done;
    logic [rbae_pkg::DIV_W-1:0] div_dividend, div_quot;
    logic [rbae_pkg::SUM_W-1:0] div_divisor;

    assign in_high  = s_tdata[PW-1:0];
    assign in_low   = s_tdata[2*PW-1:PW];
    assign in_close = s_tdata[3*PW-1:2*PW];

    assign accept    = s_tvalid && s_tready;
    assign first_bar = (bars_seen_reg == 16'd0);
    assign out_free  = !m_valid_reg || m_tready;

    // true range of the incoming bar against the previous close
    assign tr_hl  = (in_high > in_low) ? in_high - in_low : '0;
    assign tr_h   = (in_high > prev_close_reg) ? in_high - prev_close_reg
                                               : prev_close_reg - in_high;
    assign tr_l   = (in_low > prev_close_reg) ? in_low - prev_close_reg
                                              : prev_close_reg - in_low;
    always_comb begin
        tr_cur = tr_hl;
        if (tr_h > tr_cur) tr_cur = tr_h;
        if (tr_l > tr_cur) tr_cur = tr_l;
    end

    // window lengths, shrunk to the bars available
    assign look_eff = (lookback_reg == 9'd0) ? 9'd1 :
                      (lookback_reg > 9'(rbae_pkg::MAX_LOOK)) ? 9'(rbae_pkg::MAX_LOOK)
                                                             : lookback_reg;
    assign look_cnt = ({7'd0, look_eff} < bars_seen_reg) ? look_eff : bars_seen_reg[8:0];
    assign span     = {1'b0, atr_span_reg} + 7'd1;
    assign cnt2     = ({9'd0, span} < bars_seen_reg) ? span : bars_seen_reg[6:0];

    assign sum_full = win_stat.tr_sum + {{(rbae_pkg::SUM_W-PW){1'b0}}, tr_reg};

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lookback_reg <= rbae_pkg::LOOKBACK_RESET;
            atr_span_reg <= rbae_pkg::ATR_SPAN_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                rbae_pkg::CFG_LOOKBACK: lookback_reg <= cfg_wdata;
                rbae_pkg::CFG_ATR_SPAN: atr_span_reg <= cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rbae_pkg::ST_IDLE:   if (accept && !first_bar) state_next = rbae_pkg::ST_WALK;
            rbae_pkg::ST_WALK:   if (win_stat.done) state_next = rbae_pkg::ST_MUL;
            rbae_pkg::ST_MUL:    state_next = zero_reg ? rbae_pkg::ST_DONE
                                                       : rbae_pkg::ST_LAUNCH;
            rbae_pkg::ST_LAUNCH: state_next = rbae_pkg::ST_DIV_E;
            rbae_pkg::ST_DIV_E:  if (div_done) state_next = rbae_pkg::ST_DIV_A;
            rbae_pkg::ST_DIV_A:  if (div_done) state_next = rbae_pkg::ST_DONE;
            rbae_pkg::ST_DONE:   if (out_free) state_next = rbae_pkg::ST_IDLE;
            default:             state_next = rbae_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_tready          = (state_reg == rbae_pkg::ST_IDLE);
        win_cmd.start     = 1'b0;
        win_cmd.look_cnt  = look_cnt;
        win_cmd.atr_prior = cnt2 - 1'b1;
        win_cmd.wr_en     = 1'b0;
        win_cmd.wr_tr     = 1'b0;
        win_cmd.bar_high  = h_reg;
        win_cmd.bar_low   = l_reg;
        win_cmd.true_range = tr_reg;
        div_start         = 1'b0;
        div_dividend      = {prod_reg, {rbae_pkg::ENERGY_FRAC{1'b0}}};
        div_divisor       = sum_reg;
        unique case (state_reg)
            rbae_pkg::ST_IDLE: begin
                if (accept) begin
                    // first bar: store only; later bars: start the walk
                    win_cmd.start    = !first_bar;
                    win_cmd.wr_en    = first_bar;
                    win_cmd.bar_high = in_high;
                    win_cmd.bar_low  = in_low;
                end
            end
            rbae_pkg::ST_LAUNCH: div_start = 1'b1;
            rbae_pkg::ST_DIV_E: begin
                div_start    = div_done;
                div_dividend = {{(rbae_pkg::DIV_W-rbae_pkg::SUM_W-rbae_pkg::ATR_FRAC){1'b0}},
                                sum_reg, {rbae_pkg::ATR_FRAC{1'b0}}};
                div_divisor  = {{(rbae_pkg::SUM_W-rbae_pkg::ATR_CW){1'b0}}, cnt2_reg};
            end
            rbae_pkg::ST_DONE: begin
                win_cmd.wr_en = out_free;
                win_cmd.wr_tr = out_free;
            end
            default: ;
        endcase
    end

    // datapath and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= rbae_pkg::ST_IDLE;
            prev_close_reg <= '0;
            bars_seen_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (m_valid_reg && m_tready && (state_reg != rbae_pkg::ST_DONE))
                m_valid_reg <= 1'b0;
            unique case (state_reg)
                rbae_pkg::ST_IDLE: begin
                    if (accept) begin
                        h_reg    <= in_high;
                        l_reg    <= in_low;
                        c_reg    <= in_close;
                        tr_reg   <= tr_cur;
                        cnt2_reg <= cnt2;
                        if (first_bar) begin
                            prev_close_reg <= in_close;
                            bars_seen_reg  <= 16'd1;
                        end
                    end
                end
                rbae_pkg::ST_WALK: begin
                    if (win_stat.done) begin
                        hi_reg   <= win_stat.chan_high;
                        lo_reg   <= win_stat.chan_low;
                        sum_reg  <= sum_full;
                        zero_reg <= (sum_full == '0);
                        if (c_reg > win_stat.chan_high)
                            dist_reg <= c_reg - win_stat.chan_high;
                        else if (c_reg < win_stat.chan_low)
                            dist_reg <= win_stat.chan_low - c_reg;
                        else
                            dist_reg <= '0;
                    end
                end
                rbae_pkg::ST_MUL: begin
                    prod_reg   <= {{(rbae_pkg::SUM_W-PW){1'b0}}, dist_reg} *
                                  {{(rbae_pkg::SUM_W-rbae_pkg::ATR_CW){1'b0}}, cnt2_reg};
                    energy_reg <= '0;
                    atr_reg    <= '0;
                end
                rbae_pkg::ST_DIV_E: begin
                    if (div_done) begin
                        energy_reg <= (|div_quot[rbae_pkg::DIV_W-1:rbae_pkg::ENERGY_W]) ?
                                      '1 : div_quot[rbae_pkg::ENERGY_W-1:0];
                    end
                end
                rbae_pkg::ST_DIV_A: begin
                    if (div_done) begin
                        atr_reg <= (|div_quot[rbae_pkg::DIV_W-1:rbae_pkg::ATR_W]) ?
                                   '1 : div_quot[rbae_pkg::ATR_W-1:0];
                    end
                end
                rbae_pkg::ST_DONE: begin
                    if (out_free) begin
                        // hold result in the output register, commit the bar
                        m_valid_reg    <= 1'b1;
                        m_data_reg     <= {atr_reg, lo_reg, hi_reg, energy_reg};
                        m_user_reg     <= zero_reg;
                        prev_close_reg <= c_reg;
                        if (bars_seen_reg != 16'hFFFF) bars_seen_reg <= bars_seen_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    rbae_window u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (win_cmd),
        .stat    (win_stat)
    );

    rbae_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quot),
        .done     (div_done)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // a zero ATR always comes with zero energy and zero ATR value
    a_zero_atr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata[31:0] == 32'd0) && (m_tdata[135:96] == 40'd0))
        else $error("zero ATR result carries nonzero energy or ATR");

    // the walk starts only from idle, with the divider quiet
    a_walk_start: assert property (@(posedge aclk) disable iff (!aresetn)
        win_cmd.start |-> (state_reg == rbae_pkg::ST_IDLE) && !div_start)
        else $error("window walk started outside idle");

    // divider finishes only while a division is awaited
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == rbae_pkg::ST_DIV_E) || (state_reg == rbae_pkg::ST_DIV_A))
        else $error("divider finished in an unexpected state");

    // the bar count never goes backward
    a_bars_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> bars_seen_reg >= $past(bars_seen_reg))
        else $error("bar count decreased");

endmodule

// ===== design/rbae_divider.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module rbae_divider (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [rbae_pkg::DIV_W-1:0] dividend,
    input  logic [rbae_pkg::SUM_W-1:0] divisor,
    output logic [rbae_pkg::DIV_W-1:0] quotient,
    output logic                       done
);
    localparam int CNT_W = $clog2(rbae_pkg::DIV_W + 1);

    logic [rbae_pkg::DIV_W-1:0] dvd_reg;
    logic [rbae_pkg::SUM_W-1:0] dsr_reg;
    logic [rbae_pkg::SUM_W-1:0] rem_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [rbae_pkg::SUM_W:0]   rem_sh;
    logic                       ge;
    logic [rbae_pkg::SUM_W:0]   rem_sub;

    assign rem_sh  = {rem_reg, dvd_reg[rbae_pkg::DIV_W-1]};
    assign ge      = rem_sh >= {1'b0, dsr_reg};
    assign rem_sub = rem_sh - {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                dvd_reg  <= dividend;
                dsr_reg  <= divisor;
                rem_reg  <= '0;
                cnt_reg  <= CNT_W'(rbae_pkg::DIV_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= ge ? rem_sub[rbae_pkg::SUM_W-1:0] : rem_sh[rbae_pkg::SUM_W-1:0];
                dvd_reg <= {dvd_reg[rbae_pkg::DIV_W-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient = dvd_reg;
    assign done     = done_reg;
endmodule

// ===== design/rbae_window.sv =====
// High/low and true range rings with the backward walk that folds them.
`timescale 1ns / 1ps
module rbae_window (
    input  logic                aclk,
    input  logic                aresetn,
    input  rbae_pkg::win_cmd_t  cmd,
    output rbae_pkg::win_stat_t stat
);
    logic [2*rbae_pkg::PRICE_W-1:0] hl_mem [0:rbae_pkg::MAX_LOOK-1];
    logic [rbae_pkg::PRICE_W-1:0]   rr_mem [0:(1<<rbae_pkg::ATR_AW)-1];

    logic [rbae_pkg::LOOK_AW-1:0]   wp_reg, hl_addr_reg;
    logic [rbae_pkg::ATR_AW-1:0]    rp_reg, rr_addr_reg;
    logic [rbae_pkg::LOOK_CW-1:0]   hl_left_reg;
    logic [rbae_pkg::ATR_CW-1:0]    rr_left_reg;
    logic                           hl_vld_reg, rr_vld_reg, active_reg, done_reg;
    logic [2*rbae_pkg::PRICE_W-1:0] hl_q_reg;
    logic [rbae_pkg::PRICE_W-1:0]   rr_q_reg;
    logic [rbae_pkg::PRICE_W-1:0]   hi_reg, lo_reg;
    logic [rbae_pkg::SUM_W-1:0]     sum_reg;
    logic                           hl_rd, rr_rd;

    assign hl_rd = active_reg && (hl_left_reg != '0);
    assign rr_rd = active_reg && (rr_left_reg != '0);

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            hl_mem[wp_reg] <= {cmd.bar_low, cmd.bar_high};
        end
        hl_q_reg <= hl_mem[hl_addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en && cmd.wr_tr) begin
            rr_mem[rp_reg] <= cmd.true_range;
        end
        rr_q_reg <= rr_mem[rr_addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg      <= '0;
            rp_reg      <= '0;
            hl_addr_reg <= '0;
            rr_addr_reg <= '0;
            hl_left_reg <= '0;
            rr_left_reg <= '0;
            hl_vld_reg  <= 1'b0;
            rr_vld_reg  <= 1'b0;
            active_reg  <= 1'b0;
            done_reg    <= 1'b0;
            hi_reg      <= '0;
            lo_reg      <= '1;
            sum_reg     <= '0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                active_reg  <= 1'b1;
                hl_left_reg <= cmd.look_cnt;
                rr_left_reg <= cmd.atr_prior;
                hl_addr_reg <= wp_reg - 1'b1;
                rr_addr_reg <= rp_reg - 1'b1;
                hl_vld_reg  <= 1'b0;
                rr_vld_reg  <= 1'b0;
                hi_reg      <= '0;
                lo_reg      <= '1;
                sum_reg     <= '0;
            end else if (active_reg) begin
                hl_vld_reg <= hl_rd;
                rr_vld_reg <= rr_rd;
                if (hl_rd) begin
                    hl_addr_reg <= hl_addr_reg - 1'b1;
                    hl_left_reg <= hl_left_reg - 1'b1;
                end
                if (rr_rd) begin
                    rr_addr_reg <= rr_addr_reg - 1'b1;
                    rr_left_reg <= rr_left_reg - 1'b1;
                end
                if (hl_vld_reg) begin
                    if (hl_q_reg[rbae_pkg::PRICE_W-1:0] > hi_reg) begin
                        hi_reg <= hl_q_reg[rbae_pkg::PRICE_W-1:0];
                    end
                    if (hl_q_reg[2*rbae_pkg::PRICE_W-1:rbae_pkg::PRICE_W] < lo_reg) begin
                        lo_reg <= hl_q_reg[2*rbae_pkg::PRICE_W-1:rbae_pkg::PRICE_W];
                    end
                end
                if (rr_vld_reg) begin
                    sum_reg <= sum_reg + {{(rbae_pkg::SUM_W-rbae_pkg::PRICE_W){1'b0}}, rr_q_reg};
                end
                if (!hl_rd && !rr_rd && !hl_vld_reg && !rr_vld_reg) begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
            if (cmd.wr_en) begin
                wp_reg <= wp_reg + 1'b1;
                if (cmd.wr_tr) begin
                    rp_reg <= rp_reg + 1'b1;
                end
            end
        end
    end

    assign stat.done      = done_reg;
    assign stat.chan_high = hi_reg;
    assign stat.chan_low  = lo_reg;
    assign stat.tr_sum    = sum_reg;
endmodule

// ===== bench/rbae_checker.sv =====
// Checker: predicts breakout results from observed transfers and compares them.
`timescale 1ns / 1ps
module rbae_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [95:0]  s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [135:0] m_tdata,
    input  logic         m_tuser,
    input  logic         cfg_we,
    input  logic [rbae_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [rbae_pkg::CFG_W-1:0]     cfg_wdata,
    output int           fail_count,
    output int           pending_results
);
    typedef struct packed {
        logic [31:0] energy;
        logic [31:0] chan_high;
        logic [31:0] chan_low;
        logic [39:0] atr;
        logic        zero_atr;
    } breakout_t;

    breakout_t   expected_breakouts[$];
    logic [31:0] highs[rbae_pkg::MAX_LOOK];
    logic [31:0] lows[rbae_pkg::MAX_LOOK];
    logic [31:0] ranges[64];
    logic [31:0] prev_close;
    int unsigned seen_bars, wr_ptr, tr_ptr;
    logic [8:0]  look_reg;
    logic [5:0]  span_reg;

    function automatic logic [63:0] qdiv(logic [63:0] num, logic [63:0] den, int frac,
                                         logic [63:0] sat);
        logic [63:0] q, r;
        q = num / den;
        r = num % den;
        if (q > (sat >> frac)) return sat;
        for (int i = 0; i < frac; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q[0] = 1'b1;
            end
        end
        return (q > sat) ? sat : q;
    endfunction

    task automatic predict_bar(logic [31:0] h, logic [31:0] l, logic [31:0] c);
        breakout_t   b;
        logic [31:0] hi, lo, tr;
        logic [63:0] sum, distance, d;
        int unsigned look, n, span, pos;
        if (seen_bars != 0) begin
            look = (look_reg < 1) ? 1 : ((look_reg > rbae_pkg::MAX_LOOK) ? rbae_pkg::MAX_LOOK
                                                                         : look_reg);
            n = (look < seen_bars) ? look : seen_bars;
            hi = 0;
            lo = '1;
            pos = wr_ptr;
            for (int i = 0; i < n; i++) begin
                pos = (pos + rbae_pkg::MAX_LOOK - 1) % rbae_pkg::MAX_LOOK;
                if (highs[pos] > hi) hi = highs[pos];
                if (lows[pos] < lo) lo = lows[pos];
            end
            tr = (h > l) ? h - l : 0;
            d = (h > prev_close) ? h - prev_close : prev_close - h;
            if (d > tr) tr = 32'(d);
            d = (l > prev_close) ? l - prev_close : prev_close - l;
            if (d > tr) tr = 32'(d);
            ranges[tr_ptr] = tr;
            tr_ptr = (tr_ptr + 1) % 64;
            span = span_reg + 1;
            n = (span < seen_bars) ? span : seen_bars;
            sum = 0;
            pos = tr_ptr;
            for (int i = 0; i < n; i++) begin
                pos = (pos + 63) % 64;
                sum += ranges[pos];
            end
            if (c > hi) distance = c - hi;
            else if (c < lo) distance = lo - c;
            else distance = 0;
            b.chan_high = hi;
            b.chan_low = lo;
            b.zero_atr = (sum == 0);
            if (sum == 0) begin
                b.energy = 0;
                b.atr = 0;
            end else begin
                b.energy = 32'(qdiv(distance * n, sum, 16, 64'hFFFF_FFFF));
                b.atr = 40'(qdiv(sum, n, 8, 64'hFF_FFFF_FFFF));
            end
            expected_breakouts.push_back(b);
        end
        highs[wr_ptr] = h;
        lows[wr_ptr] = l;
        wr_ptr = (wr_ptr + 1) % rbae_pkg::MAX_LOOK;
        prev_close = c;
        if (seen_bars < 65535) seen_bars++;
    endtask

    always @(posedge aclk) begin
        breakout_t got, exp_b;
        if (!aresetn) begin
            expected_breakouts.delete();
            prev_close = 0;
            seen_bars = 0;
            wr_ptr = 0;
            tr_ptr = 0;
            look_reg <= rbae_pkg::LOOKBACK_RESET;
            span_reg <= rbae_pkg::ATR_SPAN_RESET;
        end else begin
            if (cfg_we) begin
                if (cfg_addr == rbae_pkg::CFG_LOOKBACK) look_reg <= cfg_wdata;
                else if (cfg_addr == rbae_pkg::CFG_ATR_SPAN) span_reg <= cfg_wdata[5:0];
            end
            if (m_tvalid && m_tready) begin
                got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tdata[135:96],
                       m_tuser};
                if (expected_breakouts.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) $display("unexpected result %h", got);
                end else begin
                    exp_b = expected_breakouts.pop_front();
                    if (got != exp_b) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch: expected e=%h hi=%h lo=%h atr=%h z=%b, ",
                                      "got e=%h hi=%h lo=%h atr=%h z=%b"},
                                     exp_b.energy, exp_b.chan_high, exp_b.chan_low,
                                     exp_b.atr, exp_b.zero_atr, got.energy,
                                     got.chan_high, got.chan_low, got.atr, got.zero_atr);
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_bar(s_tdata[31:0], s_tdata[63:32], s_tdata[95:64]);
        end
        pending_results <= expected_breakouts.size();
    end

    initial begin
        fail_count = 0;
        pending_results = 0;
    end
endmodule

// ===== bench/testbench.sv =====
// Top of the bench: drives bars, register writes and output stalls; gives the verdict.
`timescale 1ns / 1ps
module testbench;
    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [95:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;
    logic         m_tuser;
    logic         cfg_we = 1'b0;
    logic [rbae_pkg::CFG_IDX_W-1:0] cfg_addr = rbae_pkg::CFG_LOOKBACK;
    logic [rbae_pkg::CFG_W-1:0]     cfg_wdata = '0;
    int           fail_count, pending_results;
    logic [31:0]  base_price;
    int           stall_left;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    range_breakout_atr_energy_top u_dut (.*);

    rbae_checker u_checker (.*);

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 400);
    endfunction

    // Receiver stalls at random, short mostly, now and then for a long stretch.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else if (stall_left != 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 999) == 0) begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(100, 600);
        end else begin
            m_tready <= ($urandom_range(0, 9) < 7);
        end
    end

    // Offer one bar, hold it until the transfer happens, then idle for a gap.
    task automatic send_bar(logic [31:0] h, logic [31:0] l, logic [31:0] c);
        int g;
        s_tvalid <= 1'b1;
        s_tdata <= {c, l, h};
        do @(posedge aclk); while (!s_tready);
        g = gap_len();
        if (g != 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    // Drain everything, let the block settle, then write a register.
    task automatic write_reg(logic [rbae_pkg::CFG_IDX_W-1:0] idx,
                             logic [rbae_pkg::CFG_W-1:0] val);
        s_tvalid <= 1'b0;
        while (pending_results != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Random bar near a drifting base, with occasional wild fields.
    task automatic random_bar();
        logic [31:0] h, l, c;
        int spread;
        if ($urandom_range(0, 19) == 0) begin
            h = $urandom;
            l = $urandom;
            c = $urandom;
        end else begin
            spread = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 5000);
            base_price = base_price + $urandom_range(0, 2000) - 1000;
            h = base_price + $urandom_range(0, spread);
            l = base_price - $urandom_range(0, spread);
            c = $urandom_range(0, 1) ? h + $urandom_range(0, 3000)
                                     : l - $urandom_range(0, 3000);
            if ($urandom_range(0, 3) == 0) c = l + $urandom_range(0, spread);
        end
        send_bar(h, l, c);
    endtask

    initial begin
        int lk;
        int sp;
        base_price = 32'h8000_0000;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: first bar, flat bars (zero ATR), extremes, low above high.
        send_bar(32'd100, 32'd100, 32'd100);
        send_bar(32'd100, 32'd100, 32'd100);
        send_bar(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
        send_bar(32'd0, 32'hFFFF_FFFF, 32'd0);
        send_bar(32'd10, 32'd20, 32'd15);
        send_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_bar(32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd0);
        send_bar(32'd5, 32'd5, 32'd5);
        send_bar(32'd5, 32'd5, 32'd5);
        send_bar(32'd5, 32'd5, 32'hFFFF_FFFF);
        // ATR span 0 and lookback 1: one-bar windows with tiny and zero ATR.
        write_reg(rbae_pkg::CFG_ATR_SPAN, 9'd0);
        write_reg(rbae_pkg::CFG_LOOKBACK, 9'd1);
        send_bar(32'd5, 32'd4, 32'd4);
        send_bar(32'd5, 32'd4, 32'd5);
        send_bar(32'd5, 32'd5, 32'hFFFF_FFFF);
        send_bar(32'd5, 32'd5, 32'd0);
        write_reg(rbae_pkg::CFG_LOOKBACK, 9'd0);
        send_bar(32'd7, 32'd3, 32'd9);
        write_reg(rbae_pkg::CFG_LOOKBACK, 9'd511);
        write_reg(rbae_pkg::CFG_ATR_SPAN, 9'd63);
        send_bar(32'd7, 32'd3, 32'd1);
        send_bar(32'h1234_5678, 32'h0123_4567, 32'hFEDC_BA98);

        // Random phases over several settings, extremes included.
        for (int ph = 0; ph < 12; ph++) begin
            case (ph)
                0: begin lk = 256; sp = 63; end
                1: begin lk = 1;   sp = 0;  end
                2: begin lk = 257; sp = 1;  end
                default: begin
                    lk = $urandom_range(0, 3) == 0 ? $urandom_range(0, 511)
                                                   : $urandom_range(1, 40);
                    sp = $urandom_range(0, 63);
                end
            endcase
            write_reg(rbae_pkg::CFG_LOOKBACK, lk[8:0]);
            write_reg(rbae_pkg::CFG_ATR_SPAN, sp[8:0]);
            repeat (140) random_bar();
        end

        s_tvalid <= 1'b0;
        while (pending_results != 0) @(posedge aclk);
        repeat (500) @(posedge aclk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #30000000;
        $display("simulation failed");
        $finish;
    end
endmodule
